// ===== sv/pidob_pkg.sv =====
// ============================================================================
// pidob_pkg
// Shared types, widths, codes, sign-extension and saturation helpers for the PID controller
// with disturbance observer.
// ============================================================================
package pidob_pkg;

    // Fixed-point format: signed 32-bit words with FRAC_BITS fraction bits.
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 31;
    localparam int ALPHA_W   = 17;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int SUM_W     = DATA_W + 2;
    localparam int PROD_W    = 2 * DATA_W;

    typedef logic signed [DATA_W-1:0]  t_data;
    typedef logic        [GAIN_W-1:0]  t_gain;
    typedef logic        [ALPHA_W-1:0] t_alpha;
    typedef logic        [MODE_W-1:0]  t_mode;
    typedef logic signed [SUM_W-1:0]   t_sum;

    // Clamp status reported with each drive value.
    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } t_clamp;

    // Feedforward selection; the unused code behaves as FF_NONE.
    localparam t_mode FF_NONE = 2'd0;
    localparam t_mode FF_MEAS = 2'd1;
    localparam t_mode FF_OBS  = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP          = 3'd0,
        CFG_KI_DT       = 3'd1,
        CFG_KD_DIV_DT   = 3'd2,
        CFG_INV_PERIOD  = 3'd3,
        CFG_DOB_ALPHA   = 3'd4,
        CFG_SETPOINT    = 3'd5,
        CFG_DRIVE_LIMIT = 3'd6,
        CFG_FF_MODE     = 3'd7
    } t_cfg_idx;

    // Sign-extend a data word to the sum width.
    function automatic t_sum ext_sum(input t_data x);
        return {{(SUM_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

    // Saturate a sum to the signed data range.
    function automatic t_data sat_sum(input t_sum v);
        t_data res;
        if ((v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1)) begin
            res = v[DATA_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== sv/pidob_in_if.sv =====
// ============================================================================
// pidob_in_if
// Input channel: one measurement and one measured disturbance per transaction.
// ============================================================================
interface pidob_in_if;
    import pidob_pkg::*;

    logic  valid;
    logic  ready;
    t_data measurement;
    t_data measured_disturbance;

    modport source (output valid, output measurement, output measured_disturbance,
                    input ready);
    modport sink   (input valid, input measurement, input measured_disturbance,
                    output ready);
endinterface

// ===== sv/pidob_out_if.sv =====
// ============================================================================
// pidob_out_if
// Output channel: drive value, clamp status and observer estimate.
// ============================================================================
interface pidob_out_if;
    import pidob_pkg::*;

    logic   valid;
    logic   ready;
    t_data  drive;
    t_clamp clamp_state;
    t_data  disturbance_estimate;

    modport source (output valid, output drive, output clamp_state,
                    output disturbance_estimate, input ready);
    modport sink   (input valid, input drive, input clamp_state,
                    input disturbance_estimate, output ready);
endinterface

// ===== sv/pidob_mul.sv =====
// ============================================================================
// pidob_mul
// Shared fixed-point multiplier: signed word times unsigned gain, one register
// stage, then floor shift by the fraction bits and saturation.
// ============================================================================
module pidob_mul (
    input  logic             i_clk,
    input  pidob_pkg::t_data i_a,
    input  pidob_pkg::t_gain i_b,
    output pidob_pkg::t_data o_res
);
    import pidob_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] shifted;

    // Exact product; the gain is zero-extended so it is never negative.
    assign n_prod = i_a * $signed({1'b0, i_b});

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Arithmetic shift rounds toward minus infinity; then clip to 32 bits.
    assign shifted = r_prod >>> FRAC_BITS;

    always_comb begin
        if ((shifted[PROD_W-1:DATA_W-1] == '0) || (shifted[PROD_W-1:DATA_W-1] == '1)) begin
            o_res = shifted[DATA_W-1:0];
        end else if (shifted[PROD_W-1]) begin
            o_res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_res = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end
endmodule

// ===== sv/pid_with_disturbance_observer_unit.sv =====
// ============================================================================
// pid_with_disturbance_observer_unit
// PID controller with selectable disturbance feedforward and observer.
// ============================================================================
// Usage:
//   i_meas_ch carries one tick's measurement and measured disturbance; each
//   accepted transaction yields exactly one transaction on o_drive_ch with the
//   clamped drive, the clamp status and the current observer estimate.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the unit is idle; writes take effect at the next clock edge.
// Sequence:
//   Each tick steps through the difference and error step, the observer steps
//   when the observer is updated (observer feedforward, not the first tick),
//   the integral, proportional and derivative products, the PID sum, the
//   feedforward and the clamp, using one shared multiplier. Input ready is
//   high only while the sequencer is idle, so a new tick is not taken before
//   the previous one has left its last step.
// Reset and stall:
//   Synchronous active-low reset clears the controller state, marks the next
//   tick as the first one and restores the register defaults. A stalled
//   receiver holds the result; the unit still accepts one more tick and then
//   waits in its last step until the output register frees up.
// ============================================================================
module pid_with_disturbance_observer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  pidob_pkg::t_cfg_idx         i_cfg_idx,
    input  pidob_pkg::t_data            i_cfg_data,
    pidob_in_if.sink                    i_meas_ch,
    pidob_out_if.source                 o_drive_ch
);
    import pidob_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DX, S_MXP, S_PROXY, S_DIFF, S_MSTEP, S_OBS,
        S_MI, S_MP, S_MD, S_PID, S_FF, S_CLAMP
    } t_state;

    // Configuration registers.
    t_gain  r_kp, r_ki_dt, r_kd_div_dt, r_inv_period, r_drive_limit;
    t_alpha r_dob_alpha;
    t_data  r_setpoint;
    t_mode  r_ff_mode;

    // Controller state.
    t_state r_state;
    t_data  r_integ, r_prev_err, r_prev_meas, r_prev_drive, r_obs;
    logic   r_first;
    logic   r_obs_en;

    // Per-tick working registers.
    t_data  r_meas, r_mdist, r_err, r_t, r_p, r_inew;

    // Output register.
    logic   r_out_valid;
    t_data  r_out_drive, r_out_est;
    t_clamp r_out_clamp;

    // Shared multiplier operands and result.
    t_data  mul_a, mul_res;
    t_gain  mul_b;

    logic   in_fire, out_free, over, under;
    t_sum   u_ext, lim_ext, n_ff;
    t_data  lim_neg;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp          <= '0;
            r_ki_dt       <= '0;
            r_kd_div_dt   <= '0;
            r_inv_period  <= t_gain'(1 << FRAC_BITS);
            r_dob_alpha   <= '0;
            r_setpoint    <= '0;
            r_drive_limit <= '1;
            r_ff_mode     <= FF_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KP:          r_kp          <= i_cfg_data[GAIN_W-1:0];
                CFG_KI_DT:       r_ki_dt       <= i_cfg_data[GAIN_W-1:0];
                CFG_KD_DIV_DT:   r_kd_div_dt   <= i_cfg_data[GAIN_W-1:0];
                CFG_INV_PERIOD:  r_inv_period  <= i_cfg_data[GAIN_W-1:0];
                CFG_DOB_ALPHA:   r_dob_alpha   <= i_cfg_data[ALPHA_W-1:0];
                CFG_SETPOINT:    r_setpoint    <= i_cfg_data;
                CFG_DRIVE_LIMIT: r_drive_limit <= i_cfg_data[GAIN_W-1:0];
                CFG_FF_MODE:     r_ff_mode     <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = r_t;
        mul_b = '0;
        unique case (r_state)
            S_MXP:   mul_b = r_inv_period;
            S_MSTEP: mul_b = GAIN_W'(r_dob_alpha);
            S_MI: begin
                mul_a = r_err;
                mul_b = r_ki_dt;
            end
            S_MP: begin
                mul_a = r_err;
                mul_b = r_kp;
            end
            S_MD:    mul_b = r_kd_div_dt;
            default: ;
        endcase
    end

    pidob_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_res (mul_res)
    );

    // Handshakes and the clamp comparison.
    assign in_fire  = i_meas_ch.valid && i_meas_ch.ready;
    assign out_free = !r_out_valid || o_drive_ch.ready;
    assign u_ext    = ext_sum(r_t);
    assign lim_ext  = SUM_W'(r_drive_limit);
    assign lim_neg  = -t_data'({1'b0, r_drive_limit});
    assign over     = u_ext > lim_ext;
    assign under    = u_ext < -lim_ext;

    // Feedforward term; the unused mode code acts as no feedforward.
    always_comb begin
        if (r_ff_mode == FF_MEAS) begin
            n_ff = u_ext - ext_sum(r_mdist);
        end else if (r_ff_mode == FF_OBS) begin
            n_ff = u_ext - ext_sum(r_obs);
        end else begin
            n_ff = u_ext;
        end
    end

    // Sequencer: steps through the multiplies and saturating adds in turn.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_integ      <= '0;
            r_prev_err   <= '0;
            r_prev_meas  <= '0;
            r_prev_drive <= '0;
            r_obs        <= '0;
            r_first      <= 1'b1;
            r_obs_en     <= 1'b0;
        end else begin
            // The last step loads the output register itself when it is free.
            if (r_out_valid && o_drive_ch.ready && (r_state != S_CLAMP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_meas   <= i_meas_ch.measurement;
                        r_mdist  <= i_meas_ch.measured_disturbance;
                        r_obs_en <= !r_first && (r_ff_mode == FF_OBS);
                        r_state  <= S_DX;
                    end
                end
                S_DX: begin
                    r_t     <= sat_sum(ext_sum(r_meas) - ext_sum(r_prev_meas));
                    r_err   <= sat_sum(ext_sum(r_setpoint) - ext_sum(r_meas));
                    r_state <= r_obs_en ? S_MXP : S_MI;
                end
                S_MXP: r_state <= S_PROXY;
                S_PROXY: begin
                    r_t <= sat_sum(ext_sum(mul_res) + ext_sum(r_meas)
                                   - ext_sum(r_prev_drive));
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_t     <= sat_sum(ext_sum(r_t) - ext_sum(r_obs));
                    r_state <= S_MSTEP;
                end
                S_MSTEP: r_state <= S_OBS;
                S_OBS: begin
                    r_obs   <= sat_sum(ext_sum(r_obs) + ext_sum(mul_res));
                    r_state <= S_MI;
                end
                S_MI: begin
                    // Derivative of the error is held in the temp register.
                    r_t     <= sat_sum(ext_sum(r_err) - ext_sum(r_prev_err));
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_inew  <= sat_sum(ext_sum(r_integ) + ext_sum(mul_res));
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_p     <= mul_res;
                    r_state <= S_PID;
                end
                S_PID: begin
                    r_t <= sat_sum(ext_sum(r_p) + ext_sum(r_inew) + ext_sum(mul_res));
                    r_state <= S_FF;
                end
                S_FF: begin
                    r_t     <= sat_sum(n_ff);
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_est   <= r_obs;
                        r_prev_err  <= r_err;
                        r_prev_meas <= r_meas;
                        r_first     <= 1'b0;
                        if (over) begin
                            r_out_drive  <= t_data'({1'b0, r_drive_limit});
                            r_prev_drive <= t_data'({1'b0, r_drive_limit});
                            r_out_clamp  <= CLAMP_HIGH;
                        end else if (under) begin
                            r_out_drive  <= lim_neg;
                            r_prev_drive <= lim_neg;
                            r_out_clamp  <= CLAMP_LOW;
                        end else begin
                            r_out_drive  <= r_t;
                            r_prev_drive <= r_t;
                            r_out_clamp  <= CLAMP_NONE;
                            r_integ      <= r_inew;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Channel outputs.
    assign i_meas_ch.ready                 = (r_state == S_IDLE);
    assign o_drive_ch.valid                = r_out_valid;
    assign o_drive_ch.drive                = r_out_drive;
    assign o_drive_ch.clamp_state          = r_out_clamp;
    assign o_drive_ch.disturbance_estimate = r_out_est;

    // The observer never moves before the first tick has completed.
    a_obs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first |-> (r_obs == '0))
        else $error("observer estimate changed before the first tick");

    // An accepted transaction always starts the sequence.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_DX))
        else $error("accepted transaction did not start the sequence");

    // Without an observer update the sequence goes straight to the integral step.
    a_skip_obs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DX && !r_obs_en) |=> (r_state == S_MI))
        else $error("observer steps ran while disabled");

    // A clamped tick leaves the integrator unchanged.
    a_clamp_undo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAMP && out_free && (over || under)) |=> $stable(r_integ))
        else $error("integrator changed on a clamped tick");

    // A result is only loaded into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAMP && r_out_valid && !o_drive_ch.ready) |=> (r_state == S_CLAMP))
        else $error("result produced while output register was full");
endmodule
